// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the interface force block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled in reset
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled in reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- rtl/ctif_pkg.sv -----
// ----------------------------------------------------------------------------
// ctif_pkg
// Types, constants and small tables for the cohesive interface force block.
// ----------------------------------------------------------------------------
package ctif_pkg;

    // shared multiplier operand and product widths
    localparam int MUL_W  = 36;
    localparam int PROD_W = 2 * MUL_W;

    // square root: 100-bit radicand, 50-bit root, one root bit per step
    localparam int RAD_W      = 100;
    localparam int ROOT_W     = 50;
    localparam int REM_W      = 53;
    localparam int SQRT_STEPS = 50;

    localparam logic [1:0] PAIR_LAST = 2'd2;

    // ceil(2^35 / 3): exact floor(x / 3) for x below 2^33
    localparam logic [MUL_W-1:0] RECIP3 = 36'h2_AAAA_AAAB;

    // clip thresholds on the Q32 product: 12 * (limit + 1)
    localparam logic [83:0] SAT_POS_THR = 84'h6_0000_0000;
    localparam logic [83:0] SAT_NEG_THR = 84'h6_0000_000C;

    localparam logic [31:0] LIM_POS = 32'h7FFF_FFFF;
    localparam logic [31:0] LIM_NEG = 32'h8000_0000;

    // last issue tags per sequence
    localparam logic [3:0] TAG_CROSS_LAST  = 4'd5;
    localparam logic [3:0] TAG_SQUARE_LAST = 4'b1010;
    localparam logic [3:0] TAG_AREA_LAST   = 4'd1;
    localparam logic [3:0] TAG_FMUL_LAST   = 4'd2;

    typedef struct packed {
        logic             valid;
        logic             neg;
        logic [3:0]       tag;
        logic [MUL_W-1:0] a;
        logic [MUL_W-1:0] b;
    } mul_req_t;

    typedef struct packed {
        logic              valid;
        logic              neg;
        logic [3:0]        tag;
        logic [PROD_W-1:0] product;
    } mul_rsp_t;

    // cross product term k: edge-one component index
    function automatic logic [1:0] cross_l1(input logic [2:0] k);
        logic [1:0] r;
        case (k)
            3'd0:    r = 2'd1;
            3'd1:    r = 2'd2;
            3'd2:    r = 2'd2;
            3'd3:    r = 2'd0;
            3'd4:    r = 2'd0;
            3'd5:    r = 2'd1;
            default: r = 2'd0;
        endcase
        return r;
    endfunction

    // cross product term k: edge-two component index
    function automatic logic [1:0] cross_l2(input logic [2:0] k);
        logic [1:0] r;
        case (k)
            3'd0:    r = 2'd2;
            3'd1:    r = 2'd1;
            3'd2:    r = 2'd0;
            3'd3:    r = 2'd2;
            3'd4:    r = 2'd1;
            3'd5:    r = 2'd0;
            default: r = 2'd0;
        endcase
        return r;
    endfunction

endpackage

// ----- rtl/ctif_mul.sv -----
// ----------------------------------------------------------------------------
// ctif_mul
// Shared unsigned multiplier with one register stage; tag and sign ride along.
// ----------------------------------------------------------------------------
module ctif_mul (
    input  logic              aclk,
    input  logic              aresetn,
    input  ctif_pkg::mul_req_t req,
    output ctif_pkg::mul_rsp_t rsp
);

    ctif_pkg::mul_rsp_t rsp_reg;

    // product register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rsp_reg.valid <= 1'b0;
        end else begin
            rsp_reg.valid <= req.valid;
        end
        rsp_reg.neg     <= req.neg;
        rsp_reg.tag     <= req.tag;
        rsp_reg.product <= req.a * req.b;
    end

    assign rsp = rsp_reg;

endmodule

// ----- rtl/ctif_isqrt.sv -----
// ----------------------------------------------------------------------------
// ctif_isqrt
// Digit-by-digit floor square root, one root bit per cycle.
// ----------------------------------------------------------------------------
module ctif_isqrt (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [ctif_pkg::RAD_W-1:0]    radicand,
    output logic                          done,
    output logic [ctif_pkg::ROOT_W-1:0]   root
);

    logic                          busy_reg;
    logic                          done_reg;
    logic [5:0]                    cnt_reg;
    logic [ctif_pkg::RAD_W-1:0]    rad_reg;
    logic [ctif_pkg::REM_W-1:0]    rem_reg;
    logic [ctif_pkg::ROOT_W-1:0]   root_reg;
    logic [ctif_pkg::REM_W-1:0]    rem_shift;
    logic [ctif_pkg::REM_W-1:0]    trial;

    // bring down two radicand bits, trial subtract
    assign rem_shift = {rem_reg[ctif_pkg::REM_W-3:0],
                        rad_reg[ctif_pkg::RAD_W-1:ctif_pkg::RAD_W-2]};
    assign trial     = {1'b0, root_reg, 2'b01};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                rad_reg  <= radicand;
                rem_reg  <= '0;
                root_reg <= '0;
                cnt_reg  <= 6'(ctif_pkg::SQRT_STEPS - 1);
            end else if (busy_reg) begin
                if (rem_shift >= trial) begin
                    rem_reg  <= rem_shift - trial;
                    root_reg <= {root_reg[ctif_pkg::ROOT_W-2:0], 1'b1};
                end else begin
                    rem_reg  <= rem_shift;
                    root_reg <= {root_reg[ctif_pkg::ROOT_W-2:0], 1'b0};
                end
                rad_reg <= {rad_reg[ctif_pkg::RAD_W-3:0], 2'b00};
                cnt_reg <= cnt_reg - 6'd1;
                if (cnt_reg == 6'd0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

// ----- rtl/cohesive_triangle_interface_force_core.sv -----
// ----------------------------------------------------------------------------
// cohesive_triangle_interface_force_core
// Three-node linear cohesive interface force: stores three node pairs, then
// forms the triangle area and emits one saturated Q16.16 force per pair.
//
//   channel   direction  ports                                 transaction
//   s_        in         s_valid/s_ready, node pair + rest      one node pair
//   m_        out        m_valid/m_ready, pair force + flags    one pair force
//   cfg_      in         cfg_wr_en, cfg_wr_data                 modulus write
//
// Pairs 0 and 1 are only stored. Pair 2 starts the run to the first force:
// 6 cross and 9 square multiplies, 50 square-root steps, 2 area multiplies,
// then per force component 3 multiplies plus a divide-by-twelve multiply on
// the one shared multiplier. Each later pair force is computed only after the
// previous one is taken. s_ready is low until the third force is taken; reset
// needs no clear.
// ----------------------------------------------------------------------------
module cohesive_triangle_interface_force_core (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic [31:0]        cfg_wr_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [31:0] s_node_one_x,
    input  logic signed [31:0] s_node_one_y,
    input  logic signed [31:0] s_node_one_z,
    input  logic signed [31:0] s_node_two_x,
    input  logic signed [31:0] s_node_two_y,
    input  logic signed [31:0] s_node_two_z,
    input  logic signed [31:0] s_rest_x,
    input  logic signed [31:0] s_rest_y,
    input  logic signed [31:0] s_rest_z,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [1:0]         m_pair_number,
    output logic signed [31:0] m_force_x,
    output logic signed [31:0] m_force_y,
    output logic signed [31:0] m_force_z,
    output logic               m_final_force,
    output logic               m_saturated
);

`include "assert_macros.svh"

    typedef enum logic [3:0] {
        ST_IDLE, ST_EDGE, ST_CROSS, ST_ABS, ST_SQUARE, ST_SQRT,
        ST_AREA, ST_FSUM, ST_FMUL, ST_FDIV, ST_OUT
    } state_t;

    state_t state_reg;

    logic [31:0]        modulus_reg;
    logic [1:0]         pairs_loaded_reg;
    logic signed [31:0] corner_reg [3][3];
    logic signed [32:0] disp_reg   [3][3];
    logic [31:0]        lmag_reg   [2][3];
    logic               lneg_reg   [2][3];
    logic signed [34:0] tsum_reg   [3];
    logic signed [66:0] cross_reg  [3];
    logic signed [66:0] cross_acc_reg;
    logic [48:0]        m_reg      [3];
    logic [99:0]        sq_acc_reg;
    logic [48:0]        area_reg;
    logic [80:0]        p_reg;
    logic [34:0]        s_mag_reg;
    logic               s_neg_reg;
    logic [115:0]       x_acc_reg;
    logic               fsat_reg;
    logic [31:0]        force_reg  [3];
    logic               sat_acc_reg;
    logic [1:0]         k_reg;
    logic [1:0]         c_reg;
    logic [3:0]         cnt_reg;
    logic               iss_done_reg;

    ctif_pkg::mul_req_t mreq;
    ctif_pkg::mul_rsp_t mrsp;
    logic               sqrt_start;
    logic               sqrt_done;
    logic [ctif_pkg::ROOT_W-1:0] sqrt_root;

    logic [31:0]        in_one [3];
    logic [31:0]        in_two [3];
    logic [31:0]        in_rest[3];
    logic [83:0]        y_val;
    logic [3:0]         cnt_next;
    logic               last_issue;

    assign in_one  = '{s_node_one_x, s_node_one_y, s_node_one_z};
    assign in_two  = '{s_node_two_x, s_node_two_y, s_node_two_z};
    assign in_rest = '{s_rest_x, s_rest_y, s_rest_z};
    assign y_val   = x_acc_reg[115:32];

    ctif_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mreq),
        .rsp     (mrsp)
    );

    ctif_isqrt u_isqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (sqrt_start),
        .radicand (sq_acc_reg),
        .done     (sqrt_done),
        .root     (sqrt_root)
    );

    // multiplier operand select per sequence step
    always_comb begin
        logic [1:0]  i1;
        logic [1:0]  i2;
        logic [1:0]  sj;
        i1 = ctif_pkg::cross_l1(cnt_reg[2:0]);
        i2 = ctif_pkg::cross_l2(cnt_reg[2:0]);
        sj = cnt_reg[3:2];
        mreq       = '0;
        mreq.tag   = cnt_reg;
        sqrt_start = 1'b0;
        last_issue = 1'b0;
        cnt_next   = cnt_reg + 4'd1;
        case (state_reg)
            ST_CROSS: begin
                mreq.valid = !iss_done_reg;
                mreq.neg   = lneg_reg[0][i1] ^ lneg_reg[1][i2];
                mreq.a     = {4'b0, lmag_reg[0][i1]};
                mreq.b     = {4'b0, lmag_reg[1][i2]};
                last_issue = (cnt_reg == ctif_pkg::TAG_CROSS_LAST);
            end
            ST_SQUARE: begin
                mreq.valid = !iss_done_reg;
                case (cnt_reg[1:0])
                    2'd0: begin
                        mreq.a = {12'b0, m_reg[sj][48:25]};
                        mreq.b = {12'b0, m_reg[sj][48:25]};
                    end
                    2'd1: begin
                        mreq.a = {12'b0, m_reg[sj][48:25]};
                        mreq.b = {11'b0, m_reg[sj][24:0]};
                    end
                    default: begin
                        mreq.a = {11'b0, m_reg[sj][24:0]};
                        mreq.b = {11'b0, m_reg[sj][24:0]};
                    end
                endcase
                last_issue = (cnt_reg == ctif_pkg::TAG_SQUARE_LAST);
                if (cnt_reg[1:0] == 2'd2) begin
                    cnt_next = {sj + 2'd1, 2'd0};
                end
            end
            ST_SQRT: begin
                sqrt_start = !iss_done_reg;
            end
            ST_AREA: begin
                mreq.valid = !iss_done_reg;
                mreq.a     = cnt_reg[0] ? {11'b0, area_reg[24:0]} : {12'b0, area_reg[48:25]};
                mreq.b     = {4'b0, modulus_reg};
                last_issue = (cnt_reg == ctif_pkg::TAG_AREA_LAST);
            end
            ST_FMUL: begin
                mreq.valid = !iss_done_reg;
                case (cnt_reg[1:0])
                    2'd0:    mreq.a = {9'b0, p_reg[26:0]};
                    2'd1:    mreq.a = {9'b0, p_reg[53:27]};
                    default: mreq.a = {9'b0, p_reg[80:54]};
                endcase
                mreq.b     = {1'b0, s_mag_reg};
                last_issue = (cnt_reg == ctif_pkg::TAG_FMUL_LAST);
            end
            ST_FDIV: begin
                mreq.valid = !iss_done_reg;
                mreq.a     = {3'b0, y_val[34:2]};
                mreq.b     = ctif_pkg::RECIP3;
                last_issue = 1'b1;
            end
            default: begin
                mreq = '0;
            end
        endcase
    end

    // sequencer, stores and datapath registers
    always_ff @(posedge aclk) begin
        logic signed [33:0] d34;
        logic signed [32:0] l1;
        logic signed [32:0] l2;
        logic signed [66:0] pv;
        logic signed [66:0] av;
        logic signed [34:0] sv;
        logic [31:0]        q;
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            modulus_reg      <= 32'd65536;
            pairs_loaded_reg <= 2'd0;
            iss_done_reg     <= 1'b0;
            cnt_reg          <= 4'd0;
            k_reg            <= 2'd0;
            c_reg            <= 2'd0;
            sat_acc_reg      <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                modulus_reg <= cfg_wr_data;
            end

            // issue bookkeeping shared by all multiply sequences
            if (mreq.valid || sqrt_start) begin
                if (last_issue || sqrt_start) begin
                    iss_done_reg <= 1'b1;
                end else begin
                    cnt_reg <= cnt_next;
                end
            end

            case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        for (int c = 0; c < 3; c++) begin
                            corner_reg[pairs_loaded_reg][c] <= in_one[c];
                            d34 = 34'(signed'(in_one[c])) - 34'(signed'(in_two[c]))
                                - 34'(signed'(in_rest[c]));
                            if (d34[33] != d34[32]) begin
                                disp_reg[pairs_loaded_reg][c] <= {d34[33], {32{!d34[33]}}};
                            end else begin
                                disp_reg[pairs_loaded_reg][c] <= d34[32:0];
                            end
                        end
                        if (pairs_loaded_reg == ctif_pkg::PAIR_LAST) begin
                            pairs_loaded_reg <= 2'd0;
                            state_reg        <= ST_EDGE;
                        end else begin
                            pairs_loaded_reg <= pairs_loaded_reg + 2'd1;
                        end
                    end
                end
                ST_EDGE: begin
                    for (int c = 0; c < 3; c++) begin
                        l1 = 33'(corner_reg[0][c]) - 33'(corner_reg[1][c]);
                        l2 = 33'(corner_reg[2][c]) - 33'(corner_reg[1][c]);
                        lneg_reg[0][c] <= l1[32];
                        lneg_reg[1][c] <= l2[32];
                        lmag_reg[0][c] <= l1[32] ? 32'(-l1) : l1[31:0];
                        lmag_reg[1][c] <= l2[32] ? 32'(-l2) : l2[31:0];
                        tsum_reg[c]    <= 35'(disp_reg[0][c]) + 35'(disp_reg[1][c])
                                        + 35'(disp_reg[2][c]);
                    end
                    cnt_reg      <= 4'd0;
                    iss_done_reg <= 1'b0;
                    state_reg    <= ST_CROSS;
                end
                ST_CROSS: begin
                    if (mrsp.valid) begin
                        pv = {3'b0, mrsp.product[63:0]};
                        if (mrsp.neg) begin
                            pv = -pv;
                        end
                        if (!mrsp.tag[0]) begin
                            cross_acc_reg <= pv;
                        end else begin
                            cross_reg[mrsp.tag[2:1]] <= cross_acc_reg - pv;
                        end
                        if (mrsp.tag == ctif_pkg::TAG_CROSS_LAST) begin
                            state_reg <= ST_ABS;
                        end
                    end
                end
                ST_ABS: begin
                    for (int j = 0; j < 3; j++) begin
                        av = cross_reg[j][66] ? -cross_reg[j] : cross_reg[j];
                        m_reg[j] <= av[64:16];
                    end
                    sq_acc_reg   <= '0;
                    cnt_reg      <= 4'd0;
                    iss_done_reg <= 1'b0;
                    state_reg    <= ST_SQUARE;
                end
                ST_SQUARE: begin
                    if (mrsp.valid) begin
                        case (mrsp.tag[1:0])
                            2'd0: sq_acc_reg <= sq_acc_reg
                                              + {mrsp.product[49:0], 50'b0};
                            2'd1: sq_acc_reg <= sq_acc_reg
                                              + {25'b0, mrsp.product[48:0], 26'b0};
                            default: sq_acc_reg <= sq_acc_reg
                                              + {50'b0, mrsp.product[49:0]};
                        endcase
                        if (mrsp.tag == ctif_pkg::TAG_SQUARE_LAST) begin
                            iss_done_reg <= 1'b0;
                            state_reg    <= ST_SQRT;
                        end
                    end
                end
                ST_SQRT: begin
                    if (sqrt_done) begin
                        area_reg     <= sqrt_root[ctif_pkg::ROOT_W-1:1];
                        p_reg        <= '0;
                        cnt_reg      <= 4'd0;
                        iss_done_reg <= 1'b0;
                        state_reg    <= ST_AREA;
                    end
                end
                ST_AREA: begin
                    if (mrsp.valid) begin
                        if (!mrsp.tag[0]) begin
                            p_reg <= p_reg + {mrsp.product[55:0], 25'b0};
                        end else begin
                            p_reg <= p_reg + {24'b0, mrsp.product[56:0]};
                        end
                        if (mrsp.tag == ctif_pkg::TAG_AREA_LAST) begin
                            k_reg       <= 2'd0;
                            c_reg       <= 2'd0;
                            sat_acc_reg <= 1'b0;
                            state_reg   <= ST_FSUM;
                        end
                    end
                end
                ST_FSUM: begin
                    sv = tsum_reg[c_reg] + 35'(disp_reg[k_reg][c_reg]);
                    s_neg_reg    <= sv[34];
                    s_mag_reg    <= sv[34] ? 35'(-sv) : sv;
                    x_acc_reg    <= '0;
                    cnt_reg      <= 4'd0;
                    iss_done_reg <= 1'b0;
                    state_reg    <= ST_FMUL;
                end
                ST_FMUL: begin
                    if (mrsp.valid) begin
                        case (mrsp.tag[1:0])
                            2'd0: x_acc_reg <= x_acc_reg
                                             + {54'b0, mrsp.product[61:0]};
                            2'd1: x_acc_reg <= x_acc_reg
                                             + {27'b0, mrsp.product[61:0], 27'b0};
                            default: x_acc_reg <= x_acc_reg
                                             + {mrsp.product[61:0], 54'b0};
                        endcase
                        if (mrsp.tag == ctif_pkg::TAG_FMUL_LAST) begin
                            cnt_reg      <= 4'd0;
                            iss_done_reg <= 1'b0;
                            state_reg    <= ST_FDIV;
                        end
                    end
                end
                ST_FDIV: begin
                    // clip test at issue, quotient on the product
                    if (mreq.valid) begin
                        fsat_reg <= s_neg_reg ? (y_val >= ctif_pkg::SAT_NEG_THR)
                                              : (y_val >= ctif_pkg::SAT_POS_THR);
                    end
                    if (mrsp.valid) begin
                        if (fsat_reg) begin
                            q = s_neg_reg ? ctif_pkg::LIM_NEG : ctif_pkg::LIM_POS;
                        end else begin
                            q = mrsp.product[66:35];
                        end
                        force_reg[c_reg] <= s_neg_reg ? (32'd0 - q) : q;
                        sat_acc_reg      <= sat_acc_reg | fsat_reg;
                        if (c_reg == 2'd2) begin
                            state_reg <= ST_OUT;
                        end else begin
                            c_reg     <= c_reg + 2'd1;
                            state_reg <= ST_FSUM;
                        end
                    end
                end
                ST_OUT: begin
                    if (m_ready) begin
                        if (k_reg == ctif_pkg::PAIR_LAST) begin
                            state_reg <= ST_IDLE;
                        end else begin
                            k_reg       <= k_reg + 2'd1;
                            c_reg       <= 2'd0;
                            sat_acc_reg <= 1'b0;
                            state_reg   <= ST_FSUM;
                        end
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // channel outputs
    assign s_ready       = (state_reg == ST_IDLE);
    assign m_valid       = (state_reg == ST_OUT);
    assign m_pair_number = k_reg;
    assign m_force_x     = force_reg[0];
    assign m_force_y     = force_reg[1];
    assign m_force_z     = force_reg[2];
    assign m_final_force = (k_reg == ctif_pkg::PAIR_LAST);
    assign m_saturated   = sat_acc_reg;

    // checks
    `ASSERT_IMPLIES(a_no_overlap, aclk, aresetn, m_valid, !s_ready)
    `ASSERT_IMPLIES(a_pair_range, aclk, aresetn, m_valid, k_reg != 2'd3)
    `ASSERT_NEXT(a_run_ends, aclk, aresetn, m_valid && m_ready && m_final_force, s_ready)
    `ASSERT_IMPLIES(a_load_idle, aclk, aresetn, !s_ready, pairs_loaded_reg == 2'd0)
    `ASSERT_IMPLIES(a_mul_busy, aclk, aresetn, mrsp.valid, !s_ready && !m_valid)

endmodule

// ----- verif/cohesive_triangle_interface_force_core_tb.sv -----
// ----------------------------------------------------------------------------
// cohesive_triangle_interface_force_core_tb
// Drives node-pair transactions into the interface force core and checks
// every pair force against a cycle-free predictor of the element math
// (displacement, cross-product area, integer square root, E/12 scaling and
// 32-bit clipping), across several modulus settings and idle patterns.
// ----------------------------------------------------------------------------
module cohesive_triangle_interface_force_core_tb;

    localparam int  MAX_CYCLES = 600000;
    localparam int  END_WAIT   = 300;
    localparam int  DRAIN_WAIT = 20;

    typedef struct packed {
        logic [31:0] ax, ay, az;
        logic [31:0] bx, by, bz;
        logic [31:0] rx, ry, rz;
    } node_pair_t;

    typedef struct packed {
        logic [1:0]  pair;
        logic [31:0] fx, fy, fz;
        logic        fin;
        logic        sat;
    } pair_force_t;

    logic               aclk;
    logic               aresetn;
    logic               cfg_wr_en;
    logic [31:0]        cfg_wr_data;
    logic               s_valid;
    logic               s_ready;
    logic signed [31:0] s_node_one_x, s_node_one_y, s_node_one_z;
    logic signed [31:0] s_node_two_x, s_node_two_y, s_node_two_z;
    logic signed [31:0] s_rest_x, s_rest_y, s_rest_z;
    logic               m_valid;
    logic               m_ready;
    logic [1:0]         m_pair_number;
    logic signed [31:0] m_force_x, m_force_y, m_force_z;
    logic               m_final_force;
    logic               m_saturated;

    // predictor state
    logic signed [31:0] corner_mem [9];
    logic signed [32:0] disp_mem [9];
    int                 pairs_held;
    logic [31:0]        modulus;
    pair_force_t        force_q [$];

    int send_idle_pct;
    int recv_stall_pct;
    int mismatches;
    int cycles;

    cohesive_triangle_interface_force_core u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_node_one_x  (s_node_one_x),
        .s_node_one_y  (s_node_one_y),
        .s_node_one_z  (s_node_one_z),
        .s_node_two_x  (s_node_two_x),
        .s_node_two_y  (s_node_two_y),
        .s_node_two_z  (s_node_two_z),
        .s_rest_x      (s_rest_x),
        .s_rest_y      (s_rest_y),
        .s_rest_z      (s_rest_z),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_pair_number (m_pair_number),
        .m_force_x     (m_force_x),
        .m_force_y     (m_force_y),
        .m_force_z     (m_force_z),
        .m_final_force (m_final_force),
        .m_saturated   (m_saturated)
    );

    // clock
    always begin
        aclk = 1'b1;
        #10;
        aclk = 1'b0;
        #10;
    end

    // floor square root, root below 2^51
    function automatic logic [50:0] floor_sqrt(input logic [101:0] v);
        logic [50:0]  r;
        logic [50:0]  t;
        logic [101:0] sq;
        r = '0;
        for (int b = 50; b >= 0; b--) begin
            t  = r | (51'd1 << b);
            sq = t * t;
            if (sq <= v) r = t;
        end
        return r;
    endfunction

    // |a*b - c*d| >> 16 on 33-bit edge components
    function automatic logic [52:0] cross_term(input logic signed [32:0] a, b, c, d);
        logic signed [69:0] pa, pc, diff;
        pa   = a;
        pc   = c;
        pa   = pa * b;
        pc   = pc * d;
        diff = pa - pc;
        if (diff < 0) diff = -diff;
        return diff[68:16];
    endfunction

    // one clipped force component, sets sat when clipped
    function automatic logic [31:0] force_comp(input logic [50:0] area,
                                               input logic signed [35:0] s,
                                               inout logic sat);
        logic [35:0]  us;
        logic [127:0] x;
        logic [95:0]  q;
        logic [95:0]  lim;
        us  = (s < 0) ? -s : s;
        x   = area;
        x   = x * modulus;
        x   = x * us;
        q   = x[127:32] / 96'd12;
        lim = (s < 0) ? 96'h8000_0000 : 96'h7FFF_FFFF;
        if (q > lim) begin
            q   = lim;
            sat = 1'b1;
        end
        return (s < 0) ? (~q[31:0] + 32'd1) : q[31:0];
    endfunction

    // store one pair; third pair yields the three pair forces
    task automatic predict_pair(input node_pair_t p);
        logic signed [31:0] a [3];
        logic signed [31:0] b [3];
        logic signed [31:0] r [3];
        logic signed [34:0] d;
        logic signed [32:0] l1 [3];
        logic signed [32:0] l2 [3];
        logic [52:0]        m [3];
        logic [101:0]       sumsq;
        logic [50:0]        area;
        logic signed [35:0] s;
        pair_force_t        e;
        logic [31:0]        f [3];
        a = '{p.ax, p.ay, p.az};
        b = '{p.bx, p.by, p.bz};
        r = '{p.rx, p.ry, p.rz};
        for (int c = 0; c < 3; c++) begin
            corner_mem[pairs_held*3+c] = a[c];
            d = 35'(a[c]) - 35'(b[c]) - 35'(r[c]);
            if (d > 35'sh0_FFFF_FFFF)       disp_mem[pairs_held*3+c] = 33'h0_FFFF_FFFF;
            else if (d < -35'sh1_0000_0000) disp_mem[pairs_held*3+c] = 33'h1_0000_0000;
            else                            disp_mem[pairs_held*3+c] = d[32:0];
        end
        if (pairs_held < 2) begin
            pairs_held++;
            return;
        end
        pairs_held = 0;
        for (int c = 0; c < 3; c++) begin
            l1[c] = 33'(corner_mem[c])   - 33'(corner_mem[3+c]);
            l2[c] = 33'(corner_mem[6+c]) - 33'(corner_mem[3+c]);
        end
        m[0] = cross_term(l1[1], l2[2], l1[2], l2[1]);
        m[1] = cross_term(l1[2], l2[0], l1[0], l2[2]);
        m[2] = cross_term(l1[0], l2[1], l1[1], l2[0]);
        sumsq = '0;
        for (int c = 0; c < 3; c++) sumsq += 102'(m[c]) * 102'(m[c]);
        area = floor_sqrt(sumsq) >> 1;
        for (int k = 0; k < 3; k++) begin
            e.sat = 1'b0;
            for (int c = 0; c < 3; c++) begin
                s = 36'(disp_mem[c]) + 36'(disp_mem[3+c]) + 36'(disp_mem[6+c])
                  + 36'(disp_mem[k*3+c]);
                f[c] = force_comp(area, s, e.sat);
            end
            e.pair = k[1:0];
            e.fx   = f[0];
            e.fy   = f[1];
            e.fz   = f[2];
            e.fin  = (k == 2);
            force_q.push_back(e);
        end
    endtask

    // send one node pair transaction, with random lead-in idle cycles
    task automatic send_pair(input node_pair_t p);
        int  gap;
        logic rdy;
        gap = 0;
        while ($urandom_range(0, 99) < send_idle_pct) gap++;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_node_one_x <= p.ax;
        s_node_one_y <= p.ay;
        s_node_one_z <= p.az;
        s_node_two_x <= p.bx;
        s_node_two_y <= p.by;
        s_node_two_z <= p.bz;
        s_rest_x     <= p.rx;
        s_rest_y     <= p.ry;
        s_rest_z     <= p.rz;
        do begin
            @(negedge aclk);
            rdy = s_ready;
            @(posedge aclk);
        end while (!rdy);
        predict_pair(p);
    endtask

    // wait for all pending forces, then let the core settle
    task automatic drain;
        wait (force_q.size() == 0);
        @(posedge aclk);
        s_valid <= 1'b0;
        repeat (DRAIN_WAIT) @(posedge aclk);
    endtask

    task automatic write_modulus(input logic [31:0] v);
        drain();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        modulus = v;
    endtask

    function automatic logic [31:0] rand_coord;
        case ($urandom_range(0, 5))
            0:       return $urandom();
            1:       return 32'h7FFF_FFFF;
            2:       return 32'h8000_0000;
            3:       return {{12{$urandom_range(0, 1) == 1}}, 20'($urandom())};
            default: return {{8{$urandom_range(0, 1) == 1}}, 24'($urandom())};
        endcase
    endfunction

    function automatic node_pair_t rand_pair;
        node_pair_t p;
        p = {rand_coord(), rand_coord(), rand_coord(), rand_coord(), rand_coord(),
             rand_coord(), rand_coord(), rand_coord(), rand_coord()};
        return p;
    endfunction

    function automatic logic [31:0] rand_modulus;
        case ($urandom_range(0, 3))
            0:       return $urandom();
            1:       return 32'(($urandom_range(1, 64)) << 16);
            default: return 32'($urandom_range(0, 32'h000F_FFFF));
        endcase
    endfunction

    // directed: extremes, degenerate triangle, clipping, modulus extremes
    task automatic test_directed;
        node_pair_t pmax, pmin, pz;
        pmax = {9{32'h7FFF_FFFF}};
        pmin = {9{32'h8000_0000}};
        pz   = '0;
        // all pairs at the same extreme corner: degenerate
        repeat (3) send_pair(pmax);
        repeat (3) send_pair(pmin);
        // corners at opposite extremes, large displacements, clipping
        send_pair({32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0, 32'h8000_0000, 32'h8000_0000,
                   32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000});
        send_pair({32'h8000_0000, 32'h0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                   32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF});
        send_pair({32'h0, 32'h8000_0000, 32'h8000_0000, 32'h0, 32'h0, 32'h0,
                   32'h0, 32'h0, 32'h0});
        // unit right triangle, small displacements, both signs
        send_pair({32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h1_0000,
                   32'h0, 32'h0, 32'h0});
        send_pair({32'h1_0000, 32'h0, 32'h0, 32'h1_0000, 32'h0, 32'h0,
                   32'h0, 32'h0, 32'hFFFF_8000});
        send_pair({32'h0, 32'h1_0000, 32'h0, 32'h0, 32'h1_0000, 32'hFFFF_0000,
                   32'h0, 32'h0, 32'h0});
        // zero everything
        repeat (3) send_pair(pz);
        write_modulus(32'hFFFF_FFFF);
        repeat (6) send_pair(rand_pair());
        write_modulus(32'h0);
        repeat (3) send_pair(rand_pair());
    endtask

    // random triples under one idle pattern
    task automatic test_random(input int idle_pct, input int stall_pct,
                               input int triples, input logic pause_mid);
        write_modulus(rand_modulus());
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        for (int t = 0; t < triples; t++) begin
            repeat (3) send_pair(rand_pair());
            if (pause_mid && t == triples / 2) drain();
        end
    endtask

    // receiver back-pressure
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // force checker
    always @(negedge aclk) begin
        pair_force_t e;
        if (aresetn && m_valid && m_ready) begin
            if (force_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected force transaction: pair %0d", m_pair_number);
            end else begin
                e = force_q.pop_front();
                if (m_pair_number !== e.pair || m_force_x !== e.fx || m_force_y !== e.fy ||
                    m_force_z !== e.fz || m_final_force !== e.fin ||
                    m_saturated !== e.sat) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("force mismatch: exp p%0d %h %h %h f%b s%b got p%0d %h %h %h f%b s%b",
                                 e.pair, e.fx, e.fy, e.fz, e.fin, e.sat,
                                 m_pair_number, m_force_x, m_force_y, m_force_z,
                                 m_final_force, m_saturated);
                end
            end
        end
    end

    // run limit
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > MAX_CYCLES) begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin
        mismatches     = 0;
        cycles         = 0;
        pairs_held     = 0;
        modulus        = 32'h0001_0000;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        aresetn      <= 1'b0;
        cfg_wr_en    <= 1'b0;
        cfg_wr_data  <= '0;
        s_valid      <= 1'b0;
        s_node_one_x <= '0;
        s_node_one_y <= '0;
        s_node_one_z <= '0;
        s_node_two_x <= '0;
        s_node_two_y <= '0;
        s_node_two_z <= '0;
        s_rest_x     <= '0;
        s_rest_y     <= '0;
        s_rest_z     <= '0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_random(0, 0, 7, 1'b1);
        test_random(55, 0, 7, 1'b0);
        test_random(0, 55, 7, 1'b0);
        test_random(19, 19, 7, 1'b1);

        @(posedge aclk);
        s_valid <= 1'b0;
        wait (force_q.size() == 0);
        repeat (END_WAIT) @(posedge aclk);
        if (mismatches == 0 && force_q.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
